[hw/rtl/rnhl_pkg.sv]
`default_nettype none

package rnhl_pkg;

  // Operation codes carried in the request word
  localparam logic [1:0] OP_WRITE_ROUTE = 2'd0;
  localparam logic [1:0] OP_LEARN_ARP   = 2'd1;
  localparam logic [1:0] OP_LOOKUP      = 2'd2;

  localparam int unsigned COUNT_BITS      = 11;
  localparam int unsigned INDEX_BITS      = 10;
  localparam int unsigned PORT_FIELD_BITS = 4;
  localparam int unsigned PORT_WIDE_BITS  = 8;

  typedef struct packed {
    logic [1:0]                 operation;
    logic [INDEX_BITS-1:0]      route_index;
    logic [31:0]                entry_prefix;
    logic [31:0]                entry_mask;
    logic [31:0]                entry_next_hop;
    logic [PORT_FIELD_BITS-1:0] entry_port;
    logic [31:0]                learn_address;
    logic [47:0]                learn_mac;
    logic [31:0]                lookup_address;
  } req_t;

  typedef struct packed {
    logic                       route_found;
    logic [31:0]                matched_mask;
    logic [PORT_FIELD_BITS-1:0] out_port;
    logic [31:0]                hop_address;
    logic                       mac_found;
    logic [47:0]                next_hop_mac;
    logic                       learn_dropped;
  } rsp_t;

  // Winning route handed from the route scanner to the top level
  typedef struct packed {
    logic                       found;
    logic [31:0]                mask;
    logic [31:0]                hop;
    logic [PORT_FIELD_BITS-1:0] port;
  } scan_res_t;

  // Token that travels down the ARP cell chain, one cell per cycle
  typedef struct packed {
    logic        go;
    logic [31:0] key;
    logic        hit;
    logic [47:0] mac;
  } link_t;

endpackage

`default_nettype wire

[hw/rtl/rnhl_cell.sv]
`default_nettype none

module rnhl_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           live,
  input  wire logic           wr_en,
  input  wire logic [31:0]    wr_address,
  input  wire logic [47:0]    wr_mac,
  input  wire rnhl_pkg::link_t link_in,
  output rnhl_pkg::link_t     link_out
);
  import rnhl_pkg::*;

  logic [31:0] address;
  logic [47:0] mac;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      address <= wr_address;
      mac     <= wr_mac;
    end
  end

  // Pass the token on; the earliest matching cell claims it
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.go <= 1'b0;
    end else begin
      link_out.go <= link_in.go;
    end
    link_out.key <= link_in.key;
    if (link_in.hit) begin
      link_out.hit <= 1'b1;
      link_out.mac <= link_in.mac;
    end else if (live && (address == link_in.key)) begin
      link_out.hit <= 1'b1;
      link_out.mac <= mac;
    end else begin
      link_out.hit <= 1'b0;
      link_out.mac <= '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rnhl_route_scan.sv]
`default_nettype none

module rnhl_route_scan #(
  parameter int unsigned ROUTE_DEPTH = 1024,
  parameter int unsigned PORT_BITS   = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire rnhl_pkg::req_t                   req,
  input  wire logic                             start,
  input  wire logic [rnhl_pkg::COUNT_BITS-1:0]  route_count,
  output logic                                  done,
  output rnhl_pkg::scan_res_t                   result
);
  import rnhl_pkg::*;

  localparam int unsigned RA = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int unsigned LW = (RA + 1 > COUNT_BITS) ? RA + 1 : COUNT_BITS;

  logic [31:0]          mem_prefix [ROUTE_DEPTH];
  logic [31:0]          mem_mask   [ROUTE_DEPTH];
  logic [31:0]          mem_hop    [ROUTE_DEPTH];
  logic [PORT_BITS-1:0] mem_port   [ROUTE_DEPTH];

  logic [31:0]          rd_prefix;
  logic [31:0]          rd_mask;
  logic [31:0]          rd_hop;
  logic [PORT_BITS-1:0] rd_port;
  logic                 rd_valid;

  logic                 busy;
  logic [LW-1:0]        cnt;
  logic [LW-1:0]        lim;
  logic [LW-1:0]        limit_next;
  logic [31:0]          key;

  logic                 have;
  logic [31:0]          best_mask;
  logic [31:0]          best_hop;
  logic [PORT_BITS-1:0] best_port;

  logic [RA-1:0]             wr_addr;
  logic                      wr_ok;
  logic [PORT_WIDE_BITS-1:0] port_in_wide;
  logic [PORT_WIDE_BITS-1:0] port_out_wide;
  logic                      issue;
  logic                      hit;

  assign wr_addr      = RA'(req.route_index);
  assign wr_ok        = 32'(req.route_index) < 32'(ROUTE_DEPTH);
  assign port_in_wide = PORT_WIDE_BITS'(req.entry_port);
  assign issue        = busy && (cnt < lim);
  assign hit          = (key & rd_mask) == rd_prefix;

  always_comb begin
    if (LW'(route_count) > LW'(ROUTE_DEPTH)) begin
      limit_next = LW'(ROUTE_DEPTH);
    end else begin
      limit_next = LW'(route_count);
    end
  end

  // Route memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem_prefix[wr_addr] <= req.entry_prefix;
      mem_mask[wr_addr]   <= req.entry_mask;
      mem_hop[wr_addr]    <= req.entry_next_hop;
      mem_port[wr_addr]   <= port_in_wide[PORT_BITS-1:0];
    end
    rd_prefix <= mem_prefix[cnt[RA-1:0]];
    rd_mask   <= mem_mask[cnt[RA-1:0]];
    rd_hop    <= mem_hop[cnt[RA-1:0]];
    rd_port   <= mem_port[cnt[RA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= issue;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && !issue && !rd_valid) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Advance the read address and keep the best match so far
  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      lim  <= limit_next;
      key  <= req.lookup_address;
      have <= 1'b0;
    end else begin
      if (issue) begin
        cnt <= cnt + LW'(1);
      end
      if (rd_valid && hit && (!have || (rd_mask > best_mask))) begin
        have      <= 1'b1;
        best_mask <= rd_mask;
        best_hop  <= rd_hop;
        best_port <= rd_port;
      end
    end
  end

  assign port_out_wide = PORT_WIDE_BITS'(best_port);

  always_comb begin
    result.found = have && (best_mask != 32'd0);
    result.mask  = best_mask;
    result.hop   = best_hop;
    result.port  = port_out_wide[PORT_FIELD_BITS-1:0];
  end

endmodule

`default_nettype wire

[hw/rtl/route_and_next_hop_lookup_unit.sv]
`default_nettype none

// Channel  Signals                          Direction  Moves
// -------  -------------------------------  ---------  ---------------------------
// cfg      cfg_valid, cfg_ready, cfg_data   in         route_count register word
// req      req_valid, req_ready, req_data   in         operation word (rnhl_pkg::req_t)
// rsp      rsp_valid, rsp_ready, rsp_data   out        result word (rnhl_pkg::rsp_t)
//
// A route write, an ARP learn or an unknown operation goes from ST_IDLE to
// ST_EMIT and from there into the output register once that register is free.
// A lookup scans min(route_count, ROUTE_DEPTH) routes in ST_SCAN through the
// single registered read port of the route memory; when a route is found, the
// token then crosses the ARP cell chain of CACHE_DEPTH cells in ST_CHAIN.
// Reset clears the state machine, route_count and the cache fill count.
// A new request is taken as soon as the previous result sits in the output
// register; a stalled rsp channel holds that word and the next finished word
// waits in ST_EMIT, with no request taken meanwhile.

module route_and_next_hop_lookup_unit #(
  parameter int unsigned ROUTE_DEPTH = 1024,
  parameter int unsigned CACHE_DEPTH = 128,
  parameter int unsigned PORT_BITS   = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rnhl_pkg::COUNT_BITS-1:0] cfg_data,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire rnhl_pkg::req_t                  req_data,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output rnhl_pkg::rsp_t                       rsp_data
);
  import rnhl_pkg::*;

  localparam int unsigned FW = $clog2(CACHE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CHAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]            state;
  logic [COUNT_BITS-1:0] route_count;
  logic [FW-1:0]         fill;
  rsp_t                  res;
  rsp_t                  res_init;

  logic      req_fire;
  logic      learn_en;
  logic      cache_full;
  logic      scan_done;
  scan_res_t scan_res;
  link_t     link [CACHE_DEPTH+1];
  logic      emit_load;

  assign cfg_ready  = 1'b1;
  assign req_ready  = (state == ST_IDLE);
  assign req_fire   = req_valid && req_ready;
  assign cache_full = (fill == FW'(CACHE_DEPTH));
  assign learn_en   = req_fire && (req_data.operation == OP_LEARN_ARP) && !cache_full;
  assign emit_load  = (state == ST_EMIT) && (!rsp_valid || rsp_ready);

  rnhl_route_scan #(
    .ROUTE_DEPTH (ROUTE_DEPTH),
    .PORT_BITS   (PORT_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (req_fire && (req_data.operation == OP_WRITE_ROUTE)),
    .req         (req_data),
    .start       (req_fire && (req_data.operation == OP_LOOKUP)),
    .route_count (route_count),
    .done        (scan_done),
    .result      (scan_res)
  );

  // Inject the next hop into the head of the chain as the scan finishes
  always_comb begin
    link[0].go  = scan_done && scan_res.found;
    link[0].key = scan_res.hop;
    link[0].hit = 1'b0;
    link[0].mac = '0;
  end

  for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cell
    rnhl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .live       (fill > FW'(k)),
      .wr_en      (learn_en && (fill == FW'(k))),
      .wr_address (req_data.learn_address),
      .wr_mac     (req_data.learn_mac),
      .link_in    (link[k]),
      .link_out   (link[k+1])
    );
  end

  // Control: configuration, cache fill count, sequencer, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      route_count <= '0;
      fill        <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        route_count <= cfg_data;
      end
      if (learn_en) begin
        fill <= fill + FW'(1);
      end
      if (rsp_valid && rsp_ready && !emit_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if (req_data.operation == OP_LOOKUP) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (scan_res.found) begin
              state <= ST_CHAIN;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_CHAIN: begin
          if (link[CACHE_DEPTH].go) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Start every result word cleared; only a learn into a full cache flags a drop
  always_comb begin
    res_init               = '0;
    res_init.learn_dropped = (req_data.operation == OP_LEARN_ARP) && cache_full;
  end

  // Result word under construction; hold until the output register is free
  always_ff @(posedge clk) begin
    if (req_fire) begin
      res <= res_init;
    end
    if ((state == ST_SCAN) && scan_done && scan_res.found) begin
      res.route_found  <= 1'b1;
      res.matched_mask <= scan_res.mask;
      res.out_port     <= scan_res.port;
      res.hop_address  <= scan_res.hop;
    end
    if ((state == ST_CHAIN) && link[CACHE_DEPTH].go) begin
      res.mac_found    <= link[CACHE_DEPTH].hit;
      res.next_hop_mac <= link[CACHE_DEPTH].hit ? link[CACHE_DEPTH].mac : 48'd0;
    end
    if (emit_load) begin
      rsp_data <= res;
    end
  end

  // Checks on the sequencer and the cache bookkeeping
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (state == ST_SCAN))
    else $error("route scan finished outside the scan state");

  a_chain_tail_in_chain: assert property (@(posedge clk) disable iff (rst)
    link[CACHE_DEPTH].go |-> (state == ST_CHAIN))
    else $error("cache token left the chain outside the chain state");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(CACHE_DEPTH))
    else $error("cache fill count beyond cache depth");

  a_full_learn_dropped: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req_data.operation == OP_LEARN_ARP) && cache_full)
      |=> (res.learn_dropped && $stable(fill)))
    else $error("learn into a full cache was not flagged as dropped");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import rnhl_pkg::*;

  localparam int ROUTE_SLOTS = 1024;
  localparam int ARP_SLOTS   = 128;
  localparam int TAIL_CYCLES = 1400;

  // Operation code the block must treat as a no-op
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  // Next hops for the directed table
  localparam logic [31:0] HOP_A = 32'hC0A8_0001;
  localparam logic [31:0] HOP_B = 32'hC0A8_0002;
  localparam logic [31:0] HOP_C = 32'hC0A8_0003;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [COUNT_BITS-1:0] cfg_data  = '0;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req_data  = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp_data;

  always #4 clk = ~clk;

  route_and_next_hop_lookup_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  // ---------------------------------------------------------------------------
  // Forwarding state as the block should hold it, updated at each accepted word
  // ---------------------------------------------------------------------------
  logic [31:0]           fib_prefix [ROUTE_SLOTS];
  logic [31:0]           fib_mask   [ROUTE_SLOTS];
  logic [31:0]           fib_hop    [ROUTE_SLOTS];
  logic [3:0]            fib_port   [ROUTE_SLOTS];
  logic [31:0]           arp_addr   [ARP_SLOTS];
  logic [47:0]           arp_mac    [ARP_SLOTS];
  int                    arp_fill;
  logic [COUNT_BITS-1:0] fib_count;

  req_t                  request_words  [$];  // words not yet offered to the block
  rsp_t                  lookup_answers [$];  // answers owed by the block, oldest first
  logic [COUNT_BITS-1:0] count_writes   [$];  // route_count words not yet offered

  int mismatches = 0;

  // Apply one request word to the forwarding state and return the answer it owes.
  function automatic rsp_t route_answer(req_t rq);
    rsp_t ans;
    int   limit;
    int   best;
    ans = '0;
    case (rq.operation)
      OP_WRITE_ROUTE: begin
        fib_prefix[rq.route_index] = rq.entry_prefix;
        fib_mask[rq.route_index]   = rq.entry_mask;
        fib_hop[rq.route_index]    = rq.entry_next_hop;
        fib_port[rq.route_index]   = rq.entry_port;
      end
      OP_LEARN_ARP: begin
        // append only; a full cache drops the pair and flags it
        if (arp_fill < ARP_SLOTS) begin
          arp_addr[arp_fill] = rq.learn_address;
          arp_mac[arp_fill]  = rq.learn_mac;
          arp_fill++;
        end else begin
          ans.learn_dropped = 1'b1;
        end
      end
      OP_LOOKUP: begin
        // scan saturates at the table depth; largest mask wins, lowest index on a tie
        limit = (fib_count > ROUTE_SLOTS) ? ROUTE_SLOTS : int'(fib_count);
        best  = -1;
        for (int i = 0; i < limit; i++) begin
          if ((rq.lookup_address & fib_mask[i]) == fib_prefix[i] &&
              (best < 0 || fib_mask[i] > fib_mask[best]))
            best = i;
        end
        // a winner with a zero mask means no route
        if (best >= 0 && fib_mask[best] != '0) begin
          ans.route_found  = 1'b1;
          ans.matched_mask = fib_mask[best];
          ans.out_port     = fib_port[best];
          ans.hop_address  = fib_hop[best];
          // first matching cache slot wins, so duplicates resolve to the oldest
          for (int k = 0; k < arp_fill; k++) begin
            if (arp_addr[k] == fib_hop[best]) begin
              ans.mac_found    = 1'b1;
              ans.next_hop_mac = arp_mac[k];
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning: a shadow of what the queued writes will leave in the
  // table, so lookups aim at real prefixes and never reach an unwritten slot
  // ---------------------------------------------------------------------------
  logic [31:0] plan_prefix  [ROUTE_SLOTS];
  logic [31:0] plan_mask    [ROUTE_SLOTS];
  bit          plan_written [ROUTE_SLOTS];
  int          plan_count  = 0;   // saturated route_count seen by queued lookups
  int          plan_learns = 0;
  logic [31:0] net_pool [8];      // network bases, so prefixes nest and overlap
  logic [31:0] hop_pool [12];     // next hops shared by routes and ARP learns

  // Random filler in every field, so fields an operation ignores still toggle.
  function automatic req_t noise_word();
    req_t w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return w;
  endfunction

  function automatic logic [31:0] prefix_mask(int len);
    return (len == 0) ? 32'h0 : (~32'h0 << (32 - len));
  endfunction

  function automatic void push_write(int idx, logic [31:0] pfx, logic [31:0] msk,
                                     logic [31:0] hop, logic [3:0] port);
    req_t w;
    w                = noise_word();
    w.operation      = OP_WRITE_ROUTE;
    w.route_index    = INDEX_BITS'(idx);
    w.entry_prefix   = pfx;
    w.entry_mask     = msk;
    w.entry_next_hop = hop;
    w.entry_port     = port;
    plan_prefix[idx]  = pfx;
    plan_mask[idx]    = msk;
    plan_written[idx] = 1'b1;
    request_words.push_back(w);
  endfunction

  function automatic void push_learn(logic [31:0] addr, logic [47:0] mac);
    req_t w;
    w               = noise_word();
    w.operation     = OP_LEARN_ARP;
    w.learn_address = addr;
    w.learn_mac     = mac;
    plan_learns++;
    request_words.push_back(w);
  endfunction

  function automatic void push_lookup(logic [31:0] addr);
    req_t w;
    w                = noise_word();
    w.operation      = OP_LOOKUP;
    w.lookup_address = addr;
    request_words.push_back(w);
  endfunction

  function automatic void push_undefined();
    req_t w;
    w           = noise_word();
    w.operation = OP_UNDEFINED;
    request_words.push_back(w);
  endfunction

  // Mostly contiguous masks over pooled networks; some non-contiguous masks and
  // some prefixes with bits outside the mask, which can never match.
  function automatic void rand_write(int idx);
    logic [31:0] msk;
    logic [31:0] pfx;
    logic [31:0] hop;
    msk = ($urandom_range(0, 9) == 0) ? $urandom : prefix_mask($urandom_range(0, 32));
    pfx = net_pool[$urandom_range(0, 7)] & msk;
    if ($urandom_range(0, 11) == 0)
      pfx = $urandom;
    hop = ($urandom_range(0, 7) == 0) ? $urandom : hop_pool[$urandom_range(0, 11)];
    push_write(idx, pfx, msk, hop, 4'($urandom));
  endfunction

  // Aim most lookups inside a live route; the rest land anywhere.
  function automatic void rand_lookup();
    int          slot;
    logic [31:0] addr;
    if (plan_count > 0 && $urandom_range(0, 4) != 0) begin
      slot = $urandom_range(0, plan_count - 1);
      addr = plan_prefix[slot] | ($urandom & ~plan_mask[slot]);
    end else if ($urandom_range(0, 1) == 0) begin
      addr = net_pool[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(0, 31));
    end else begin
      addr = $urandom;
    end
    push_lookup(addr);
  endfunction

  function automatic void rand_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      if (plan_count > 0 && $urandom_range(0, 3) != 0)
        rand_write($urandom_range(0, plan_count - 1));
      else
        rand_write($urandom_range(0, ROUTE_SLOTS - 1));
    end else if (pick < 52) begin
      push_learn(($urandom_range(0, 3) != 0) ? hop_pool[$urandom_range(0, 11)] : $urandom,
                 48'({$urandom, $urandom}));
    end else if (pick < 96) begin
      rand_lookup();
    end else begin
      push_undefined();
    end
  endfunction

  // Fill every slot that a route_count of n would expose.
  function automatic void cover_slots(int n);
    for (int i = 0; i < n; i++)
      if (!plan_written[i])
        rand_write(i);
  endfunction

  // Hold until every queued word is taken and every owed answer has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (request_words.size() != 0 || req_valid || lookup_answers.size() != 0);
  endtask

  // Expose the needed slots, drain the block, then rewrite route_count.
  task automatic enter_phase(int value);
    cover_slots((value > ROUTE_SLOTS) ? ROUTE_SLOTS : value);
    wait_idle();
    count_writes.push_back(COUNT_BITS'(value));
    do @(negedge clk);
    while (count_writes.size() != 0 || cfg_valid);
    plan_count = (value > ROUTE_SLOTS) ? ROUTE_SLOTS : value;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers config and request words, and folds every accepted word
  // into the forwarding state at the edge that takes it
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      cfg_valid  <= 1'b0;
      fib_count  = '0;
      arp_fill   = 0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        fib_count = cfg_data;
      if (req_valid && req_ready)
        lookup_answers.push_back(route_answer(req_data));

      // advance the config channel once its word is gone
      if (!cfg_valid || cfg_ready) begin
        if (count_writes.size() != 0) begin
          cfg_valid <= 1'b1;
          cfg_data  <= count_writes.pop_front();
        end else begin
          cfg_valid <= 1'b0;
        end
      end

      // advance the request channel; hold the word while it waits
      if (!req_valid || req_ready) begin
        if (burst_left == 0 && gap_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
        end
        if (gap_left > 0) begin
          req_valid <= 1'b0;
          gap_left--;
        end else if (request_words.size() != 0) begin
          req_valid <= 1'b1;
          req_data  <= request_words.pop_front();
          burst_left--;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls the result channel on its own pattern and checks each
  // accepted result word against the oldest owed answer
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [47:0] want_v, logic [47:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  int stall_left;
  int run_left;

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left = 0;
      run_left   = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (lookup_answers.size() == 0) begin
          $error("result word with no request outstanding");
          mismatches++;
        end else begin
          want = lookup_answers.pop_front();
          check_field("route_found",   48'(want.route_found),   48'(rsp_data.route_found));
          check_field("matched_mask",  48'(want.matched_mask),  48'(rsp_data.matched_mask));
          check_field("out_port",      48'(want.out_port),      48'(rsp_data.out_port));
          check_field("hop_address",   48'(want.hop_address),   48'(rsp_data.hop_address));
          check_field("mac_found",     48'(want.mac_found),     48'(rsp_data.mac_found));
          check_field("next_hop_mac",  want.next_hop_mac,       rsp_data.next_hop_mac);
          check_field("learn_dropped", 48'(want.learn_dropped), 48'(rsp_data.learn_dropped));
        end
      end

      // stall for a while, then run; now and then a long run with no stall
      if (stall_left == 0 && run_left == 0) begin
        run_left   = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 20);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
        run_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed table, then random phases over several route counts
  // ---------------------------------------------------------------------------
  initial begin
    int spans [8];
    spans = '{0, 1, 5, 16, 33, 48, 12, 2};
    foreach (net_pool[k]) net_pool[k] = $urandom;
    foreach (hop_pool[k]) hop_pool[k] = $urandom;

    // empty table with route_count at reset, and an undefined operation
    push_lookup(HOP_A);
    push_undefined();

    // default route with a zero mask: matches all but never counts as a route
    push_write(0, 32'h0000_0000, 32'h0000_0000, HOP_A, 4'd0);
    push_write(1, 32'h0A00_0000, 32'hFF00_0000, HOP_A, 4'd1);
    // equal prefix and mask twice: the lower index must win
    push_write(2, 32'h0A01_0000, 32'hFFFF_0000, HOP_B, 4'd2);
    push_write(3, 32'h0A01_0000, 32'hFFFF_0000, HOP_C, 4'd3);
    // host route at the top of every field
    push_write(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    // non-contiguous mask that beats a /4 on plain unsigned compare
    push_write(5, 32'h1010_1010, 32'hF0F0_F0F0, HOP_C, 4'd5);
    // prefix with bits outside its mask: can never match
    push_write(6, 32'h0A00_00FF, 32'hFF00_0000, HOP_A, 4'd6);
    push_write(7, 32'h1000_0000, 32'hF000_0000, HOP_B, 4'd7);

    // duplicate learn for HOP_B: the older pair must answer; HOP_C stays unknown
    push_learn(HOP_A, 48'hFFFF_FFFF_FFFF);
    push_learn(HOP_B, 48'h0000_0000_0001);
    push_learn(HOP_B, 48'h0200_0000_0002);
    push_learn(32'h0000_0000, 48'h0000_0000_0000);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    enter_phase(8);
    push_lookup(32'h0A01_0203);  // tie on /16, cached hop
    push_lookup(32'h0A7F_0000);  // /8 only
    push_lookup(32'hFFFF_FFFF);  // host route, hop not cached
    push_lookup(32'h1A1B_1C1D);  // non-contiguous mask wins over /4
    push_lookup(32'hC0A8_0001);  // only the zero-mask route matches
    push_lookup(32'h0000_0000);

    foreach (spans[p]) begin
      enter_phase(spans[p]);
      repeat (55) rand_item();
    end

    // make sure the cache overflows
    while (plan_learns < ARP_SLOTS + 8)
      push_learn(hop_pool[$urandom_range(0, 11)], 48'({$urandom, $urandom}));

    enter_phase(20);
    repeat (40) rand_item();

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && lookup_answers.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Drop the run if it hangs
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
